// ===== hw/rtl/psq_pkg.sv =====
package psq_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int SLOT_DEPTH   = 1024;
  localparam int LINE_DEPTH   = 256;
  localparam int GROUP_DEPTH  = 16;
  localparam int MAX_POINTS   = 32;

  localparam int VERTEX_AW = $clog2(VERTEX_DEPTH);
  localparam int SLOT_AW   = $clog2(SLOT_DEPTH);
  localparam int LINE_AW   = $clog2(LINE_DEPTH);
  localparam int GROUP_AW  = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int K_W       = $clog2(MAX_POINTS);

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef enum logic [2:0] {
    CMD_WR_VTX   = 3'd0,
    CMD_WR_SLOT  = 3'd1,
    CMD_WR_LINE  = 3'd2,
    CMD_WR_GROUP = 3'd3,
    CMD_FLOOR    = 3'd4,
    CMD_WALL     = 3'd5,
    CMD_LR_EDGE  = 3'd6,
    CMD_UD_EDGE  = 3'd7
  } psq_cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LINE  = 2'd1,
    ERR_DEGEN = 2'd2
  } psq_err_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [9:0]         address;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic [15:0]        vertex_flags;
    logic [9:0]         vertex_ref;
    logic [9:0]         first_slot;
    logic [5:0]         slot_count;
    logic [3:0]         group_ref;
    logic signed [23:0] object_x;
    logic signed [23:0] object_y;
    logic               side;
  } psq_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [23:0] gap;
    logic [15:0]        surface_flags;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [23:0] edge_x;
    logic signed [23:0] edge_y;
    logic [1:0]         error;
  } psq_out_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        flags;
  } psq_vtx_t;

  typedef struct packed {
    logic [9:0] first;
    logic [5:0] count;
    logic [3:0] group;
  } psq_line_t;

  typedef struct packed {
    logic     load_in;
    logic     do_write;
    logic     line_rd;
    logic     line_use;
    logic     slot_rd;
    logic     vtx_rd;
    logic     lat_a;
    logic     lat_b;
    logic     sidx_last;
    logic     sidx_second;
    logic     sidx_next;
    logic     clamp;
    logic     walk_adv;
    logic     mul;
    logic     div_int_start;
    logic     gap_lat;
    logic     nrm_init;
    logic     nrm_shift;
    logic     nrm_sq;
    logic     nrm_sum;
    logic     div_nrm_start;
    logic     sqrt_start;
    logic     nrm_lat;
    logic     nrm_sel;
    logic     res_err;
    psq_err_e err_code;
    logic     res_edge;
    logic     out_load;
  } psq_ctl_t;

  typedef struct packed {
    psq_cmd_e cmd;
    logic     line_oor;
    logic     miss;
    logic     seg_equal;
    logic     seg_hit;
    logic     k_last;
    logic     nrm_big;
    logic     div_done;
    logic     sqrt_done;
    logic     out_free;
  } psq_sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
    logic signed [23:0] r;
    if (v > 29'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -29'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/polyline_surface_query_top.sv =====
// Polyline surface lookup.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one command per
// transfer: four table writes (vertex, slot, line, group offset) and four
// queries (floor, wall, left/right edge, up/down edge) against a line.
// Output channel (out_valid_o/out_ready_i, out_data_o) gives exactly one
// result per command; writes give an all-zero result.
// Items are handled one at a time. Writes and a bad line number go
// straight to the result; queries read the first and last vertex, and
// edge queries and floor/wall misses end there. Other floor/wall queries
// walk the k segments examined; a degenerate segment ends the walk with
// an error. A finished walk uses the shared 64-step divider once for
// interpolation; a floor hit then prescales by s (0..9) shifts and uses
// the divider twice more for the normal, each time followed by a 16-step
// square root.
// Reset clears the group offsets to zero; vertex, slot and line tables are
// undefined until written. The result waits in an output register while
// the receiver stalls; the next command is taken meanwhile and held back
// only when its own result is ready to be loaded.
module polyline_surface_query_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psq_pkg::psq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psq_pkg::psq_out_t out_data_o
);
  import psq_pkg::*;

  psq_ctl_t ctl;
  psq_sts_t sts;

  psq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  psq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/psq_div.sv =====
module psq_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [psq_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [psq_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [psq_pkg::DIV_DEN_W-1:0]  quot_o
);
  import psq_pkg::*;

  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q, quo_q, rem_n;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  // restoring division, one numerator bit per cycle
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_n = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= {quo_q[DIV_DEN_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hw/rtl/psq_dp.sv =====
module psq_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psq_pkg::psq_ctl_t  ctl_i,
  output psq_pkg::psq_sts_t  sts_o,
  input  psq_pkg::psq_in_t   in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output psq_pkg::psq_out_t  out_data_o
);
  import psq_pkg::*;

  psq_in_t   in_q;
  psq_out_t  res_q, out_q;
  logic      out_valid_q;

  psq_vtx_t  vtx_mem [VERTEX_DEPTH];
  logic [VERTEX_AW-1:0] slot_mem [SLOT_DEPTH];
  psq_line_t line_mem [LINE_DEPTH];
  logic signed [23:0] grp_x_q [GROUP_DEPTH];
  logic signed [23:0] grp_y_q [GROUP_DEPTH];

  psq_vtx_t  vtx_rd_q, va_q, vb_q;
  logic [VERTEX_AW-1:0] slot_rd_q;
  psq_line_t line_rd_q;

  logic [SLOT_AW-1:0] first_q, sidx_q;
  logic [CNT_W-1:0]   n_q, n_c;
  logic [K_W-1:0]     k_q;
  logic signed [23:0] gx_q, gy_q, gx, gy;
  logic signed [24:0] p_q, o_q;
  logic signed [49:0] prod_q;
  logic signed [24:0] den_q;
  logic signed [23:0] b1_q;
  logic               neg_q;

  logic [24:0] ax_q, ay_q;
  logic        dxneg_q, dyneg_q, dyzero_q;
  logic [29:0] sqx_q, sqy_q;
  logic [30:0] s_q;
  logic [15:0] mnx_q;

  logic [31:0] sq_rem_q, sq_res_q, sq_bit_q;
  logic        sq_busy_q, sq_done_q;

  logic        div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den, div_quot;

  logic axis, vtx_we, slot_we, line_we, grp_we;
  logic signed [23:0] a1, a2, b1, b2, near_c, far_c, ca, cb;
  logic signed [24:0] dpa, dbb, dx, dy;
  logic [49:0] un;
  logic [24:0] ud;
  logic signed [27:0] qs;
  logic signed [28:0] diff;
  logic [32:0] sq_trial;
  logic [15:0] m_w;
  logic signed [15:0] nxs, nys;
  psq_vtx_t pick;

  assign axis = (psq_cmd_e'(in_q.command) == CMD_WALL)
             || (psq_cmd_e'(in_q.command) == CMD_UD_EDGE);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // table writes
  assign vtx_we  = ctl_i.do_write && psq_cmd_e'(in_q.command) == CMD_WR_VTX
                && 32'(in_q.address) < 32'(VERTEX_DEPTH);
  assign slot_we = ctl_i.do_write && psq_cmd_e'(in_q.command) == CMD_WR_SLOT
                && 32'(in_q.address) < 32'(SLOT_DEPTH);
  assign line_we = ctl_i.do_write && psq_cmd_e'(in_q.command) == CMD_WR_LINE
                && 32'(in_q.address) < 32'(LINE_DEPTH);
  assign grp_we  = ctl_i.do_write && psq_cmd_e'(in_q.command) == CMD_WR_GROUP
                && 32'(in_q.address) < 32'(GROUP_DEPTH);

  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem[in_q.address[VERTEX_AW-1:0]] <= '{x: in_q.coord_x, y: in_q.coord_y,
                                                flags: in_q.vertex_flags};
    end
    if (ctl_i.vtx_rd) begin
      vtx_rd_q <= vtx_mem[slot_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[in_q.address[SLOT_AW-1:0]] <= in_q.vertex_ref[VERTEX_AW-1:0];
    end
    if (ctl_i.slot_rd) begin
      slot_rd_q <= slot_mem[sidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[in_q.address[LINE_AW-1:0]] <= '{first: in_q.first_slot,
                                              count: in_q.slot_count,
                                              group: in_q.group_ref};
    end
    if (ctl_i.line_rd) begin
      line_rd_q <= line_mem[in_q.address[LINE_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GROUP_DEPTH; i++) begin
        grp_x_q[i] <= '0;
        grp_y_q[i] <= '0;
      end
    end else if (grp_we) begin
      grp_x_q[in_q.address[GROUP_AW-1:0]] <= in_q.coord_x;
      grp_y_q[in_q.address[GROUP_AW-1:0]] <= in_q.coord_y;
    end
  end

  assign gx = grp_x_q[line_rd_q.group[GROUP_AW-1:0]];
  assign gy = grp_y_q[line_rd_q.group[GROUP_AW-1:0]];

  always_comb begin
    if (32'(line_rd_q.count) < 32'd2) begin
      n_c = CNT_W'(2);
    end else if (32'(line_rd_q.count) > 32'(MAX_POINTS)) begin
      n_c = CNT_W'(MAX_POINTS);
    end else begin
      n_c = CNT_W'(line_rd_q.count);
    end
  end

  // segment geometry along the query axis
  always_comb begin
    a1 = axis ? va_q.y : va_q.x;
    a2 = axis ? vb_q.y : vb_q.x;
    b1 = axis ? va_q.x : va_q.y;
    b2 = axis ? vb_q.x : vb_q.y;
    near_c = (a1 < a2) ? a1 : a2;
    far_c  = (a1 < a2) ? a2 : a1;
    dpa = p_q - 25'(a1);
    dbb = 25'(b2) - 25'(b1);
    dx  = 25'(vb_q.x) - 25'(va_q.x);
    dy  = 25'(vb_q.y) - 25'(va_q.y);
    un  = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
    ud  = den_q[24] ? 25'(-den_q) : 25'(den_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.line_use) begin
      first_q <= line_rd_q.first[SLOT_AW-1:0];
      n_q     <= n_c;
      gx_q    <= gx;
      gy_q    <= gy;
      p_q     <= axis ? 25'(in_q.object_y) - 25'(gy) : 25'(in_q.object_x) - 25'(gx);
      o_q     <= axis ? 25'(in_q.object_x) - 25'(gx) : 25'(in_q.object_y) - 25'(gy);
    end else if (ctl_i.clamp) begin
      if (p_q < 25'(near_c)) begin
        p_q <= 25'(near_c);
      end else if (p_q > 25'(far_c)) begin
        p_q <= 25'(far_c);
      end
    end
    if (ctl_i.line_use) begin
      sidx_q <= line_rd_q.first[SLOT_AW-1:0];
    end else if (ctl_i.sidx_last) begin
      sidx_q <= SLOT_AW'(first_q + SLOT_AW'(n_q) - SLOT_AW'(1));
    end else if (ctl_i.sidx_second) begin
      sidx_q <= first_q + SLOT_AW'(1);
    end else if (ctl_i.sidx_next) begin
      sidx_q <= sidx_q + SLOT_AW'(1);
    end
    if (ctl_i.clamp) begin
      k_q <= '0;
    end else if (ctl_i.walk_adv) begin
      k_q <= k_q + K_W'(1);
    end
    if (ctl_i.lat_a) begin
      va_q <= vtx_rd_q;
    end else if (ctl_i.walk_adv) begin
      va_q <= vb_q;
    end
    if (ctl_i.lat_b) begin
      vb_q <= vtx_rd_q;
    end
    if (ctl_i.mul) begin
      prod_q <= 50'(dpa) * 50'(dbb);
      den_q  <= 25'(a2) - 25'(a1);
      b1_q   <= b1;
    end
    if (ctl_i.div_int_start) begin
      neg_q <= prod_q[49] ^ den_q[24];
    end
    if (ctl_i.nrm_init) begin
      ax_q     <= dx[24] ? 25'(-dx) : 25'(dx);
      ay_q     <= dy[24] ? 25'(-dy) : 25'(dy);
      dxneg_q  <= dx[24];
      dyneg_q  <= dy[24];
      dyzero_q <= (dy == '0);
    end else if (ctl_i.nrm_shift) begin
      ax_q <= ax_q >> 1;
      ay_q <= ay_q >> 1;
    end
    if (ctl_i.nrm_sq) begin
      sqx_q <= 30'(ax_q[14:0]) * 30'(ax_q[14:0]);
      sqy_q <= 30'(ay_q[14:0]) * 30'(ay_q[14:0]);
    end
    if (ctl_i.nrm_sum) begin
      s_q <= 31'(sqx_q) + 31'(sqy_q);
    end
    if (ctl_i.nrm_lat && !ctl_i.nrm_sel) begin
      mnx_q <= m_w;
    end
  end

  // shared divider: interpolation quotient and the normal's squared ratio
  assign div_start = ctl_i.div_int_start | ctl_i.div_nrm_start;
  always_comb begin
    if (ctl_i.div_nrm_start) begin
      div_num = {4'b0, (ctl_i.nrm_sel ? sqx_q : sqy_q), 30'b0};
      div_den = {1'b0, s_q};
    end else begin
      div_num = DIV_NUM_W'({un, 1'b0}) + DIV_NUM_W'(ud);
      div_den = DIV_DEN_W'({ud, 1'b0});
    end
  end

  psq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // bitwise integer square root, one result bit per cycle
  assign sq_trial = {1'b0, sq_res_q} + {1'b0, sq_bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
    end else begin
      sq_done_q <= 1'b0;
      if (ctl_i.sqrt_start) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && sq_bit_q == 32'd1) begin
        sq_busy_q <= 1'b0;
        sq_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sqrt_start) begin
      sq_rem_q <= div_quot;
      sq_res_q <= '0;
      sq_bit_q <= 32'h4000_0000;
    end else if (sq_busy_q) begin
      if ({1'b0, sq_rem_q} >= sq_trial) begin
        sq_rem_q <= 32'({1'b0, sq_rem_q} - sq_trial);
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // largest m with (2m-1)^2 <= ratio
  assign m_w = 16'((17'(sq_res_q[15:0]) + 17'd1) >> 1);

  always_comb begin
    nxs = $signed(mnx_q);
    nys = $signed(m_w);
    if (dxneg_q == dyneg_q) begin
      nxs = -nxs;
    end
    if (dyzero_q) begin
      nxs = '0;
    end
    if (!in_q.side) begin
      nxs = -nxs;
      nys = -nys;
    end
  end

  always_comb begin
    qs = $signed({1'b0, div_quot[26:0]});
    if (neg_q) begin
      qs = -qs;
    end
    diff = 29'(b1_q) + 29'(qs) - 29'(o_q);
  end

  always_comb begin
    ca = axis ? va_q.y : va_q.x;
    cb = axis ? vb_q.y : vb_q.x;
    if (in_q.side ? (cb < ca) : (ca < cb)) begin
      pick = va_q;
    end else begin
      pick = vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      res_q <= '0;
    end else begin
      if (ctl_i.res_err) begin
        res_q.error <= ctl_i.err_code;
      end
      if (ctl_i.gap_lat) begin
        res_q.hit           <= 1'b1;
        res_q.gap           <= sat24(diff);
        res_q.surface_flags <= va_q.flags;
      end
      if (ctl_i.res_edge) begin
        res_q.hit    <= 1'b1;
        res_q.edge_x <= sat24(29'(pick.x) + 29'(gx_q));
        res_q.edge_y <= sat24(29'(pick.y) + 29'(gy_q));
      end
      if (ctl_i.nrm_lat && ctl_i.nrm_sel) begin
        res_q.normal_x <= nxs;
        res_q.normal_y <= nys;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.cmd       = psq_cmd_e'(in_q.command);
    sts_o.line_oor  = 32'(in_q.address) >= 32'(LINE_DEPTH);
    sts_o.miss      = (26'(p_q) < 26'(near_c) - 26'sd1) || (26'(p_q) > 26'(far_c) + 26'sd1);
    sts_o.seg_equal = (a1 == a2);
    sts_o.seg_hit   = (25'(a1) <= p_q && p_q <= 25'(a2)) || (25'(a2) <= p_q && p_q <= 25'(a1));
    sts_o.k_last    = CNT_W'(k_q) == n_q - CNT_W'(2);
    sts_o.nrm_big   = (|ax_q[24:15]) || (|ay_q[24:15]);
    sts_o.div_done  = div_done;
    sts_o.sqrt_done = sq_done_q;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

// ===== hw/rtl/psq_ctrl.sv =====
module psq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psq_pkg::psq_sts_t  sts_i,
  output psq_pkg::psq_ctl_t  ctl_o
);
  import psq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LINE, S_SLOT_A, S_VTX_A, S_LAT_A, S_SLOT_B, S_VTX_B,
    S_LAT_B, S_RANGE, S_WSLOT, S_WVTX, S_WLAT, S_WCHK, S_MUL, S_DIV, S_DWAIT,
    S_NINIT, S_NSHIFT, S_NSQ, S_NSUM, S_NDIV, S_NDWAIT, S_NSQRT, S_NSWAIT, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic   is_edge, is_write;

  assign is_edge  = (sts_i.cmd == CMD_LR_EDGE) || (sts_i.cmd == CMD_UD_EDGE);
  assign is_write = (sts_i.cmd == CMD_WR_VTX) || (sts_i.cmd == CMD_WR_SLOT)
                 || (sts_i.cmd == CMD_WR_LINE) || (sts_i.cmd == CMD_WR_GROUP);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    ctl_o   = '0;
    ctl_o.nrm_sel = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (is_write) begin
          ctl_o.do_write = 1'b1;
          state_d = S_FINISH;
        end else if (sts_i.line_oor) begin
          ctl_o.res_err  = 1'b1;
          ctl_o.err_code = ERR_LINE;
          state_d = S_FINISH;
        end else begin
          ctl_o.line_rd = 1'b1;
          state_d = S_LINE;
        end
      end
      S_LINE: begin
        ctl_o.line_use = 1'b1;
        state_d = S_SLOT_A;
      end
      S_SLOT_A: begin
        ctl_o.slot_rd = 1'b1;
        state_d = S_VTX_A;
      end
      S_VTX_A: begin
        ctl_o.vtx_rd = 1'b1;
        state_d = S_LAT_A;
      end
      S_LAT_A: begin
        ctl_o.lat_a     = 1'b1;
        ctl_o.sidx_last = 1'b1;
        state_d = S_SLOT_B;
      end
      S_SLOT_B: begin
        ctl_o.slot_rd = 1'b1;
        state_d = S_VTX_B;
      end
      S_VTX_B: begin
        ctl_o.vtx_rd = 1'b1;
        state_d = S_LAT_B;
      end
      S_LAT_B: begin
        ctl_o.lat_b = 1'b1;
        state_d = S_RANGE;
      end
      S_RANGE: begin
        if (is_edge) begin
          ctl_o.res_edge = 1'b1;
          state_d = S_FINISH;
        end else if (sts_i.miss) begin
          state_d = S_FINISH;
        end else begin
          ctl_o.clamp       = 1'b1;
          ctl_o.sidx_second = 1'b1;
          state_d = S_WSLOT;
        end
      end
      S_WSLOT: begin
        ctl_o.slot_rd = 1'b1;
        state_d = S_WVTX;
      end
      S_WVTX: begin
        ctl_o.vtx_rd = 1'b1;
        state_d = S_WLAT;
      end
      S_WLAT: begin
        ctl_o.lat_b = 1'b1;
        state_d = S_WCHK;
      end
      S_WCHK: begin
        if (sts_i.seg_equal) begin
          ctl_o.res_err  = 1'b1;
          ctl_o.err_code = ERR_DEGEN;
          state_d = S_FINISH;
        end else if (sts_i.seg_hit || sts_i.k_last) begin
          state_d = S_MUL;
        end else begin
          ctl_o.walk_adv  = 1'b1;
          ctl_o.sidx_next = 1'b1;
          state_d = S_WSLOT;
        end
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_int_start = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          ctl_o.gap_lat = 1'b1;
          state_d = (sts_i.cmd == CMD_WALL) ? S_FINISH : S_NINIT;
        end
      end
      S_NINIT: begin
        ctl_o.nrm_init = 1'b1;
        state_d = S_NSHIFT;
      end
      S_NSHIFT: begin
        if (sts_i.nrm_big) begin
          ctl_o.nrm_shift = 1'b1;
        end else begin
          state_d = S_NSQ;
        end
      end
      S_NSQ: begin
        ctl_o.nrm_sq = 1'b1;
        state_d = S_NSUM;
      end
      S_NSUM: begin
        ctl_o.nrm_sum = 1'b1;
        sel_d = 1'b0;
        state_d = S_NDIV;
      end
      S_NDIV: begin
        ctl_o.div_nrm_start = 1'b1;
        state_d = S_NDWAIT;
      end
      S_NDWAIT: begin
        if (sts_i.div_done) begin
          state_d = S_NSQRT;
        end
      end
      S_NSQRT: begin
        ctl_o.sqrt_start = 1'b1;
        state_d = S_NSWAIT;
      end
      S_NSWAIT: begin
        if (sts_i.sqrt_done) begin
          ctl_o.nrm_lat = 1'b1;
          if (sel_q) begin
            state_d = S_FINISH;
          end else begin
            sel_d = 1'b1;
            state_d = S_NDIV;
          end
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an untaken result");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISPATCH))
    else $error("accepted transfer not dispatched");

  a_idle_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.div_done)
    else $error("divider finished while idle");

  a_gap_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.gap_lat |-> sts_i.div_done)
    else $error("gap latched without quotient");

endmodule
